// ===== hw/rtl/paa_pkg.sv =====
// ----------------------------------------------------------------------------
// paa_pkg
// Shared widths, register codes, job record and clamp helpers for the
// piecewise aggregate approximation block.
// ----------------------------------------------------------------------------
package paa_pkg;

    localparam int MAX_SERIES_LENGTH = 1024;
    localparam int MAX_SEGMENTS      = 64;

    localparam int SAMPLE_W    = 32;
    localparam int LEN_W       = 11;
    localparam int CNT_W       = 7;
    localparam int IDX_W       = 6;
    localparam int SUM_W       = SAMPLE_W + LEN_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = LEN_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SERIES_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0] RESET_SERIES_LENGTH = LEN_W'(256);
    localparam logic [CNT_W-1:0] RESET_SEGMENT_COUNT = CNT_W'(16);

    // one closed segment on its way to the divider
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [LEN_W-1:0]        len;
        logic [CNT_W-1:0]        idx;
        logic                    last_flag;
    } t_seg_job;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_DIV  = 3'b010,
        BK_DONE = 3'b100
    } t_back_state;

    function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] l;
        l = raw;
        if (raw == '0) begin
            l = LEN_W'(1);
        end else if (int'(raw) > MAX_SERIES_LENGTH) begin
            l = LEN_W'(MAX_SERIES_LENGTH);
        end
        return l;
    endfunction

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] raw,
                                                   input logic [LEN_W-1:0] len);
        logic [CNT_W-1:0] c;
        c = raw;
        if (raw == '0) begin
            c = CNT_W'(1);
        end else if (int'(raw) > MAX_SEGMENTS) begin
            c = CNT_W'(MAX_SEGMENTS);
        end
        if (LEN_W'(c) > len) begin
            c = CNT_W'(len);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/paa_front.sv =====
// ----------------------------------------------------------------------------
// paa_front
// Configuration registers, segment length setup and the running sum. Emits
// one job per closed segment.
// ----------------------------------------------------------------------------
module paa_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [paa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [paa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_item_valid,
    input  logic signed [paa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_setup_busy,
    output logic                               o_job_wr,
    output paa_pkg::t_seg_job                  o_job
);

    localparam int LEN_W  = paa_pkg::LEN_W;
    localparam int CNT_W  = paa_pkg::CNT_W;
    localparam int SUM_W  = paa_pkg::SUM_W;
    localparam int DCNT_W = $clog2(LEN_W + 1);

    logic [LEN_W-1:0]  r_series_length, n_series_length;
    logic [CNT_W-1:0]  r_segment_count, n_segment_count;
    logic              r_dirty, n_dirty;
    logic              r_busy, n_busy;
    logic [DCNT_W-1:0] r_dcnt, n_dcnt;
    logic [CNT_W-1:0]  r_cd_div, n_cd_div;
    logic [LEN_W-1:0]  r_cd_quo, n_cd_quo;
    logic [CNT_W-1:0]  r_cd_rem, n_cd_rem;
    logic [LEN_W-1:0]  r_base, n_base;
    logic [CNT_W-1:0]  r_extra, n_extra;
    logic [CNT_W-1:0]  r_cnt_eff, n_cnt_eff;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [CNT_W-1:0]  r_seg, n_seg;
    logic signed [SUM_W-1:0] r_sum, n_sum;

    logic [LEN_W-1:0]        cd_len;
    logic [CNT_W-1:0]        cd_cnt;
    logic [CNT_W:0]          cd_shift;
    logic                    cd_ge;
    logic [LEN_W-1:0]        seg_len;
    logic [LEN_W-1:0]        pos_next;
    logic signed [SUM_W-1:0] sum_next;
    logic                    seg_close;
    logic                    seg_last;
    logic                    cfg_wr;

    assign o_cfg_ready  = 1'b1;
    assign cfg_wr       = i_cfg_valid;
    assign o_setup_busy = r_dirty | r_busy;

    assign cd_len   = paa_pkg::eff_length(r_series_length);
    assign cd_cnt   = paa_pkg::eff_count(r_segment_count, cd_len);
    assign cd_shift = {r_cd_rem, r_cd_quo[LEN_W-1]};
    assign cd_ge    = cd_shift >= {1'b0, r_cd_div};

    // first (L mod C) segments take one sample more
    assign seg_len   = r_base + LEN_W'(r_seg < r_extra);
    assign pos_next  = r_pos + LEN_W'(1);
    assign sum_next  = r_sum + SUM_W'(i_sample);
    assign seg_close = pos_next == seg_len;
    assign seg_last  = ({1'b0, r_seg} + (CNT_W+1)'(1)) >= {1'b0, r_cnt_eff};

    assign o_job_wr       = i_item_valid & seg_close;
    assign o_job.sum      = sum_next;
    assign o_job.len      = seg_len;
    assign o_job.idx      = r_seg;
    assign o_job.last_flag = seg_last;

    always_comb begin
        n_series_length = r_series_length;
        n_segment_count = r_segment_count;
        n_dirty   = r_dirty;
        n_busy    = r_busy;
        n_dcnt    = r_dcnt;
        n_cd_div  = r_cd_div;
        n_cd_quo  = r_cd_quo;
        n_cd_rem  = r_cd_rem;
        n_base    = r_base;
        n_extra   = r_extra;
        n_cnt_eff = r_cnt_eff;
        n_pos     = r_pos;
        n_seg     = r_seg;
        n_sum     = r_sum;

        // base = L / C, extra = L mod C, one quotient bit per cycle
        if (r_dirty) begin
            n_cd_quo  = cd_len;
            n_cd_div  = cd_cnt;
            n_cd_rem  = '0;
            n_dcnt    = DCNT_W'(LEN_W);
            n_busy    = 1'b1;
            n_dirty   = 1'b0;
            n_cnt_eff = cd_cnt;
        end else if (r_busy) begin
            n_cd_rem = cd_ge ? CNT_W'(cd_shift - {1'b0, r_cd_div}) : CNT_W'(cd_shift);
            n_cd_quo = {r_cd_quo[LEN_W-2:0], cd_ge};
            n_dcnt   = r_dcnt - DCNT_W'(1);
            if (r_dcnt == DCNT_W'(1)) begin
                n_busy  = 1'b0;
                n_base  = n_cd_quo;
                n_extra = n_cd_rem;
            end
        end

        if (i_item_valid) begin
            if (seg_close) begin
                n_pos = '0;
                n_sum = '0;
                n_seg = seg_last ? '0 : r_seg + CNT_W'(1);
            end else begin
                n_pos = pos_next;
                n_sum = sum_next;
            end
        end

        if (cfg_wr) begin
            case (i_cfg_index)
                paa_pkg::REG_SERIES_LENGTH: begin
                    n_series_length = i_cfg_data;
                    n_dirty = 1'b1;
                    n_pos   = '0;
                    n_seg   = '0;
                    n_sum   = '0;
                end
                paa_pkg::REG_SEGMENT_COUNT: begin
                    n_segment_count = i_cfg_data[CNT_W-1:0];
                    n_dirty = 1'b1;
                    n_pos   = '0;
                    n_seg   = '0;
                    n_sum   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_series_length <= paa_pkg::RESET_SERIES_LENGTH;
            r_segment_count <= paa_pkg::RESET_SEGMENT_COUNT;
            r_dirty   <= 1'b1;
            r_busy    <= 1'b0;
            r_dcnt    <= '0;
            r_cnt_eff <= CNT_W'(1);
            r_pos     <= '0;
            r_seg     <= '0;
            r_sum     <= '0;
        end else begin
            r_series_length <= n_series_length;
            r_segment_count <= n_segment_count;
            r_dirty   <= n_dirty;
            r_busy    <= n_busy;
            r_dcnt    <= n_dcnt;
            r_cnt_eff <= n_cnt_eff;
            r_pos     <= n_pos;
            r_seg     <= n_seg;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cd_div <= n_cd_div;
        r_cd_quo <= n_cd_quo;
        r_cd_rem <= n_cd_rem;
        r_base   <= n_base;
        r_extra  <= n_extra;
    end

`ifndef SYNTH
    a_no_job_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_wr |-> !o_setup_busy)
        else $error("segment job issued during length setup");

    a_seg_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_setup_busy |-> (r_seg < r_cnt_eff))
        else $error("segment index beyond segment count");
`endif

endmodule

// ===== hw/rtl/paa_queue.sv =====
// ----------------------------------------------------------------------------
// paa_queue
// Short FIFO of closed-segment jobs between the accumulator and the divider.
// ----------------------------------------------------------------------------
module paa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  paa_pkg::t_seg_job i_wr_data,
    output logic              o_full,
    output logic              o_valid,
    output paa_pkg::t_seg_job o_rd_data,
    input  logic              i_rd
);

    localparam int DEPTH = paa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    paa_pkg::t_seg_job r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full    = r_count == CNT_W'(DEPTH);
    assign o_valid   = r_count != '0;
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr & ~o_full;
    assign do_rd     = i_rd & o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("job queue written while full");
`endif

endmodule

// ===== hw/rtl/paa_back.sv =====
// ----------------------------------------------------------------------------
// paa_back
// Signed segment sum over segment length, restoring division one bit per
// cycle, followed by the result register.
// ----------------------------------------------------------------------------
module paa_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_job_valid,
    input  paa_pkg::t_seg_job                  i_job,
    output logic                               o_job_rd,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [paa_pkg::SAMPLE_W-1:0] o_segment_mean,
    output logic [paa_pkg::IDX_W-1:0]          o_segment_index,
    output logic                               o_last_of_series
);

    localparam int LEN_W  = paa_pkg::LEN_W;
    localparam int CNT_W  = paa_pkg::CNT_W;
    localparam int SUM_W  = paa_pkg::SUM_W;
    localparam int SMP_W  = paa_pkg::SAMPLE_W;
    localparam int IDX_W  = paa_pkg::IDX_W;
    localparam int STEP_W = $clog2(SUM_W);

    paa_pkg::t_back_state r_state, n_state;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [SUM_W-1:0]     r_quo, n_quo;
    logic [LEN_W-1:0]     r_rem, n_rem;
    logic [LEN_W-1:0]     r_div, n_div;
    logic                 r_neg, n_neg;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic                 r_last, n_last;
    logic                 r_out_valid, n_out_valid;
    logic [SMP_W-1:0]     r_out_mean, n_out_mean;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;
    logic                 r_out_last, n_out_last;

    logic [SUM_W-1:0] job_mag;
    logic [LEN_W:0]   div_shift;
    logic             div_ge;
    logic [SMP_W-1:0] quo_low;
    logic             out_pop;

    assign job_mag   = i_job.sum[SUM_W-1] ? (~i_job.sum + SUM_W'(1)) : i_job.sum;
    assign div_shift = {r_rem, r_quo[SUM_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_div};
    assign quo_low   = r_quo[SMP_W-1:0];
    assign out_pop   = i_pop & r_out_valid;

    assign o_job_rd         = (r_state == paa_pkg::BK_IDLE) & i_job_valid;
    assign o_empty          = ~r_out_valid;
    assign o_segment_mean   = r_out_mean;
    assign o_segment_index  = r_out_idx;
    assign o_last_of_series = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_last      = r_last;
        n_out_valid = r_out_valid & ~out_pop;
        n_out_mean  = r_out_mean;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;

        case (r_state)
            paa_pkg::BK_IDLE: begin
                if (i_job_valid) begin
                    n_quo   = job_mag;
                    n_rem   = '0;
                    n_div   = i_job.len;
                    n_neg   = i_job.sum[SUM_W-1];
                    n_idx   = i_job.idx;
                    n_last  = i_job.last_flag;
                    n_step  = STEP_W'(SUM_W - 1);
                    n_state = paa_pkg::BK_DIV;
                end
            end
            paa_pkg::BK_DIV: begin
                n_rem  = div_ge ? LEN_W'(div_shift - {1'b0, r_div}) : LEN_W'(div_shift);
                n_quo  = {r_quo[SUM_W-2:0], div_ge};
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = paa_pkg::BK_DONE;
                end
            end
            paa_pkg::BK_DONE: begin
                // magnitude always fits the sample width; sign goes back on here
                if (!r_out_valid || i_pop) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_neg ? (~quo_low + SMP_W'(1)) : quo_low;
                    n_out_idx   = IDX_W'(r_idx);
                    n_out_last  = r_last;
                    n_state     = paa_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = paa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= paa_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_div      <= n_div;
        r_neg      <= n_neg;
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_out_mean <= n_out_mean;
        r_out_idx  <= n_out_idx;
        r_out_last <= n_out_last;
    end

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == paa_pkg::BK_DONE) |-> (r_rem < r_div))
        else $error("division remainder not below segment length");

    a_job_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_rd |=> (r_state == paa_pkg::BK_DIV))
        else $error("job taken but division not started");
`endif

endmodule

// ===== hw/rtl/piecewise_aggregate_approx.sv =====
// ----------------------------------------------------------------------------
// piecewise_aggregate_approx
// Streaming segment means of fixed-length Q16.16 series.
// ----------------------------------------------------------------------------
// The accumulator takes one sample per cycle while full is low and closes
// segments; each closed segment is queued (two deep) and divided by its
// length in a restoring divider that yields one quotient bit per cycle; the
// back end loads the job, runs 43 division steps and writes the result.
// Samples flow at one per cycle while the queue has room; the divider takes
// a new segment only after its last result is written, so with short
// segments full rises while the queue holds two pending segments.
// After reset and after every write to the length or count register, full
// stays high while the segment base length and remainder are computed.
// ----------------------------------------------------------------------------
module piecewise_aggregate_approx (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [paa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [paa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic signed [paa_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [paa_pkg::SAMPLE_W-1:0] o_segment_mean,
    output logic [paa_pkg::IDX_W-1:0]          o_segment_index,
    output logic                               o_last_of_series
);

    logic              setup_busy;
    logic              queue_full;
    logic              item_valid;
    logic              job_wr;
    paa_pkg::t_seg_job job_in;
    logic              job_valid;
    paa_pkg::t_seg_job job_out;
    logic              job_rd;

    assign full       = setup_busy | queue_full;
    assign item_valid = push & ~full;

    paa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (item_valid),
        .i_sample     (i_sample),
        .o_setup_busy (setup_busy),
        .o_job_wr     (job_wr),
        .o_job        (job_in)
    );

    paa_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_wr),
        .i_wr_data (job_in),
        .o_full    (queue_full),
        .o_valid   (job_valid),
        .o_rd_data (job_out),
        .i_rd      (job_rd)
    );

    paa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job_valid      (job_valid),
        .i_job            (job_out),
        .o_job_rd         (job_rd),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_segment_mean   (o_segment_mean),
        .o_segment_index  (o_segment_index),
        .o_last_of_series (o_last_of_series)
    );

endmodule
